// ----- sv/gcs_pkg.sv -----
// Shared types and constants for the grapheme cluster segmenter.
`default_nettype none
package gcs_pkg;

  localparam int unsigned POSITION_BITS_DEF = 32;
  localparam int unsigned LENGTH_BITS_DEF   = 16;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned BC_W    = 3;
  localparam int unsigned START_W = 32;
  localparam int unsigned BYTES_W = 16;

  localparam int unsigned QUEUE_DEPTH = 4;

  // Character classes of one codepoint.
  typedef struct packed {
    logic cr;
    logic lf;
    logic ri;
    logic hl;
    logic hv;
    logic ht;
    logic extend;
    logic zwj;
    logic prepend;
  } cp_class_t;

  typedef struct packed {
    logic [START_W-1:0] cluster_start;
    logic [BYTES_W-1:0] cluster_bytes;
    logic               final_cluster;
    logic               last_of_item;
  } cluster_t;

  // Up to two words are pushed toward the output per accepted item.
  typedef struct packed {
    logic     push0;
    logic     push1;
    cluster_t word0;
    cluster_t word1;
  } push_t;

endpackage
`default_nettype wire

// ----- sv/gcs_if.sv -----
// Handshake interfaces for the codepoint and cluster channels.
`default_nettype none
interface gcs_item_if;
  import gcs_pkg::*;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] codepoint;
  logic [BC_W-1:0] byte_count;
  logic            end_of_text;

  modport source (output valid, codepoint, byte_count, end_of_text, input ready);
  modport sink (input valid, codepoint, byte_count, end_of_text, output ready);
endinterface

interface gcs_cluster_if;
  import gcs_pkg::*;
  logic               valid;
  logic               ready;
  logic [START_W-1:0] cluster_start;
  logic [BYTES_W-1:0] cluster_bytes;
  logic               final_cluster;
  logic               last_of_item;

  modport source (output valid, cluster_start, cluster_bytes, final_cluster,
                  last_of_item, input ready);
  modport sink (input valid, cluster_start, cluster_bytes, final_cluster,
                last_of_item, output ready);
endinterface
`default_nettype wire

// ----- sv/gcs_classify.sv -----
// Range compares that sort one codepoint into its segmentation classes.
`default_nettype none
module gcs_classify
  import gcs_pkg::*;
(
  input  logic [CP_W-1:0] codepoint,
  output cp_class_t       cls
);

  function automatic logic in_rng(input logic [CP_W-1:0] c,
                                  input logic [CP_W-1:0] lo,
                                  input logic [CP_W-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  logic [CP_W-1:0] c;
  assign c = codepoint;

  always_comb begin
    cls.cr = (c == 21'h0000d);
    cls.lf = (c == 21'h0000a);
    cls.ri = in_rng(c, 21'h1f1e6, 21'h1f1ff);
    cls.hl = in_rng(c, 21'h01100, 21'h0115f) || in_rng(c, 21'h0a960, 21'h0a97c);
    cls.hv = in_rng(c, 21'h01160, 21'h011a7) || in_rng(c, 21'h0d7b0, 21'h0d7c6);
    cls.ht = in_rng(c, 21'h011a8, 21'h011ff) || in_rng(c, 21'h0d7cb, 21'h0d7fb);
    cls.extend = in_rng(c, 21'h00300, 21'h0036f) || in_rng(c, 21'h01ab0, 21'h01aff) ||
                 in_rng(c, 21'h01dc0, 21'h01dff) || in_rng(c, 21'h020d0, 21'h020ff) ||
                 in_rng(c, 21'h0fe00, 21'h0fe0f) || in_rng(c, 21'h1f3fb, 21'h1f3ff) ||
                 in_rng(c, 21'h1f7e0, 21'h1faff) || in_rng(c, 21'h00903, 21'h0093c) ||
                 in_rng(c, 21'h00a3e, 21'h00a42) || in_rng(c, 21'h00bbe, 21'h00bce) ||
                 in_rng(c, 21'h1d165, 21'h1d169) || in_rng(c, 21'he0020, 21'he007f);
    cls.zwj = (c == 21'h0200d);
    cls.prepend = in_rng(c, 21'h00600, 21'h00605) || (c == 21'h006dd) ||
                  (c == 21'h0070f) || in_rng(c, 21'h00890, 21'h00891) ||
                  (c == 21'h00d4e) || (c == 21'h110bd) ||
                  in_rng(c, 21'h111c2, 21'h111c3) || (c == 21'h1193f) ||
                  (c == 21'h11941) || (c == 21'h11a3a) ||
                  in_rng(c, 21'h11a84, 21'h11a89) || (c == 21'h11d46);
  end

endmodule
`default_nettype wire

// ----- sv/gcs_tracker.sv -----
// Open cluster state, join rules and generation of closed cluster words.
`default_nettype none
module gcs_tracker
  import gcs_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  cp_class_t       cls,
  input  logic [BC_W-1:0] byte_count,
  input  logic            end_of_text,
  output push_t           push
);

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_CR,
    KIND_RI,
    KIND_L,
    KIND_V,
    KIND_GEN,
    KIND_JOIN
  } kind_t;

  kind_t                    open_kind, open_kind_next;
  logic [POSITION_BITS-1:0] open_start, open_start_next;
  logic [LENGTH_BITS-1:0]   open_length, open_length_next;
  logic [POSITION_BITS-1:0] text_position, text_position_next;

  logic                     absorbed, pair_closed, emit_prev, emit_last;
  kind_t                    kind_mid, start_kind, kind1;
  logic [POSITION_BITS-1:0] start1;
  logic [LENGTH_BITS-1:0]   len1, len_abs, len_new;
  logic [LENGTH_BITS:0]     sum_abs, sum_new;
  cluster_t                 prev_word, last_word;

  function automatic cluster_t make_word(input logic [POSITION_BITS-1:0] st,
                                         input logic [LENGTH_BITS-1:0] ln,
                                         input logic fin, input logic last);
    logic [POSITION_BITS+START_W-1:0] st_ext;
    logic [LENGTH_BITS+BYTES_W-1:0]   ln_ext;
    cluster_t w;
    st_ext = {{START_W{1'b0}}, st};
    ln_ext = {{BYTES_W{1'b0}}, ln};
    w.cluster_start = st_ext[START_W-1:0];
    w.cluster_bytes = ln_ext[BYTES_W-1:0];
    w.final_cluster = fin;
    w.last_of_item  = last;
    return w;
  endfunction

  // Saturating lengths: a carry out of the sum means the maximum was passed.
  assign sum_abs = {1'b0, open_length} + (LENGTH_BITS+1)'(byte_count);
  assign sum_new = (LENGTH_BITS+1)'(byte_count);
  assign len_abs = sum_abs[LENGTH_BITS] ? '1 : sum_abs[LENGTH_BITS-1:0];
  assign len_new = sum_new[LENGTH_BITS] ? '1 : sum_new[LENGTH_BITS-1:0];

  always_comb begin
    absorbed    = 1'b0;
    pair_closed = 1'b0;
    kind_mid    = open_kind;
    unique case (open_kind)
      KIND_NONE: ;
      KIND_RI: begin
        if (cls.ri) begin
          absorbed    = 1'b1;
          pair_closed = 1'b1;
        end
      end
      KIND_L: absorbed = cls.hl || cls.hv;
      KIND_V: absorbed = cls.hv || cls.ht;
      default: begin
        priority if (open_kind == KIND_CR && cls.lf && byte_count == BC_W'(1)) begin
          absorbed    = 1'b1;
          pair_closed = 1'b1;
        end else if (cls.extend) begin
          absorbed = 1'b1;
          if (open_kind == KIND_CR) kind_mid = KIND_GEN;
        end else if (cls.zwj) begin
          absorbed = 1'b1;
          kind_mid = KIND_JOIN;
        end else if (open_kind == KIND_JOIN) begin
          absorbed = 1'b1;
          kind_mid = KIND_GEN;
        end else begin
          absorbed = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    priority if (cls.cr) start_kind = KIND_CR;
    else if (cls.ri)      start_kind = KIND_RI;
    else if (cls.hl)      start_kind = KIND_L;
    else if (cls.hv)      start_kind = KIND_V;
    else if (cls.prepend) start_kind = KIND_JOIN;
    else                  start_kind = KIND_GEN;
  end

  always_comb begin
    if (absorbed) begin
      start1 = open_start;
      len1   = len_abs;
      kind1  = kind_mid;
    end else begin
      start1 = text_position;
      len1   = len_new;
      kind1  = start_kind;
    end
    emit_prev = !absorbed && (open_kind != KIND_NONE);
    emit_last = pair_closed || end_of_text;
    prev_word = make_word(open_start, open_length, 1'b0, !emit_last);
    last_word = make_word(start1, len1, end_of_text, 1'b1);

    push.push0 = fire && (emit_prev || emit_last);
    push.push1 = fire && emit_prev && emit_last;
    push.word0 = emit_prev ? prev_word : last_word;
    push.word1 = last_word;

    if (end_of_text) begin
      open_kind_next     = KIND_NONE;
      open_start_next    = '0;
      open_length_next   = '0;
      text_position_next = '0;
    end else begin
      open_kind_next     = pair_closed ? KIND_NONE : kind1;
      open_start_next    = start1;
      open_length_next   = len1;
      text_position_next = text_position + POSITION_BITS'(byte_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_kind     <= KIND_NONE;
      open_start    <= '0;
      open_length   <= '0;
      text_position <= '0;
    end else if (fire) begin
      open_kind     <= open_kind_next;
      open_start    <= open_start_next;
      open_length   <= open_length_next;
      text_position <= text_position_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/gcs_result_queue.sv -----
// Small result queue that takes up to two words per cycle and hands out one.
`default_nettype none
module gcs_result_queue
  import gcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  output logic             room,
  gcs_cluster_if.source    clusters
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cluster_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W-1:0]  wr_ptr1;
  logic [CNT_W-1:0]  count, count_next;
  logic              pop;
  logic [1:0]        n_push;
  cluster_t          head;

  assign wr_ptr1 = wr_ptr + PTR_W'(1);
  assign pop     = clusters.valid && clusters.ready;
  assign n_push  = {1'b0, push.push0} + {1'b0, push.push1};
  assign count_next = count + CNT_W'(n_push) - CNT_W'(pop);
  // Room for the worst case of two words from the next item.
  assign room = count <= CNT_W'(QUEUE_DEPTH - 2);

  assign head                   = entries[rd_ptr];
  assign clusters.valid         = count != '0;
  assign clusters.cluster_start = head.cluster_start;
  assign clusters.cluster_bytes = head.cluster_bytes;
  assign clusters.final_cluster = head.final_cluster;
  assign clusters.last_of_item  = head.last_of_item;

  always_ff @(posedge clk) begin
    if (push.push0) entries[wr_ptr] <= push.word0;
    if (push.push1) entries[wr_ptr1] <= push.word1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(n_push);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/grapheme_cluster_segmenter.sv -----
// Grapheme cluster segmenter: codepoints in, closed cluster offsets and lengths out.
// Each accepted codepoint passes through an input register; the cluster words it closes then go into the result queue.
// Throughput: one codepoint per cycle; input stalls only while the four-word
// result queue has fewer than two free entries.
// Reset clears the open cluster, the text position and the result queue.
`default_nettype none
module grapheme_cluster_segmenter
  import gcs_pkg::*;
#(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF,
  parameter int unsigned LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  gcs_item_if.sink      items,
  gcs_cluster_if.source clusters
);

  logic            s1_valid;
  logic [CP_W-1:0] s1_codepoint;
  logic [BC_W-1:0] s1_byte_count;
  logic            s1_end_of_text;
  logic            room, fire;
  cp_class_t       cls;
  push_t           push;

  assign fire        = s1_valid && room;
  assign items.ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      s1_codepoint   <= items.codepoint;
      s1_byte_count  <= items.byte_count;
      s1_end_of_text <= items.end_of_text;
    end
  end

  gcs_classify u_classify (
    .codepoint (s1_codepoint),
    .cls       (cls)
  );

  gcs_tracker #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .cls         (cls),
    .byte_count  (s1_byte_count),
    .end_of_text (s1_end_of_text),
    .push        (push)
  );

  gcs_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .clusters (clusters)
  );

endmodule
`default_nettype wire
